>>> rtl/tgt_pkg.sv
// Shared types and constants of the twiddle gain tuner.
`default_nettype none

package tgt_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;
  localparam int K_W = 32;
  localparam int FRAC = 30;
  localparam int NUM_GAINS = 3;
  // Wide enough for a sum of three 64-bit values plus sign.
  localparam int SUM_W = 66;

  // Scale factors in Q2.30.
  localparam logic signed [K_W-1:0] K_TENTH = 32'sd107374182;
  localparam logic signed [K_W-1:0] K_FIFTH = 32'sd214748365;
  localparam logic signed [K_W-1:0] K_GROW = 32'sd1181116006;
  localparam logic signed [K_W-1:0] K_SHRINK = 32'sd966367642;

  localparam logic signed [SUM_W-1:0] MAX64 = (SUM_W'(1) <<< 63) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] MIN64 = -MAX64 - SUM_W'(1);

  localparam logic [1:0] REG_KP = 2'd0;
  localparam logic [1:0] REG_KD = 2'd1;
  localparam logic [1:0] REG_KI = 2'd2;

  localparam logic [1:0] LAST_IDX = 2'(NUM_GAINS - 1);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_UP    = 2'd1,
    PH_DOWN  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    RS_IDLE  = 2'd0,
    RS_LOAD  = 2'd1,
    RS_DELTA = 2'd2,
    RS_TOL   = 2'd3
  } restart_t;

  typedef struct packed {
    logic load_gains;
    logic load_deltas;
    logic load_tol;
    logic busy;
  } restart_ctl_t;

endpackage

`default_nettype wire

>>> rtl/tgt_ifs.sv
// Valid/ready channel interfaces for error samples and tuned gains.
`default_nettype none

interface tgt_in_if import tgt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] error_sample;

  modport source (output valid, output error_sample, input ready);
  modport sink (input valid, input error_sample, output ready);
endinterface

interface tgt_out_if import tgt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] gain_p;
  logic signed [DATA_W-1:0] gain_d;
  logic signed [DATA_W-1:0] gain_i;
  logic                     converged;

  modport source (output valid, output gain_p, output gain_d, output gain_i,
                  output converged, input ready);
  modport sink (input valid, input gain_p, input gain_d, input gain_i,
                input converged, output ready);
endinterface

`default_nettype wire

>>> rtl/twiddle_gain_tuner.sv
// Twiddle coordinate search over three PID gains, one error sample per step.
//
// Usage: the APB port writes initial_kp, initial_kd and initial_ki at byte
// addresses 0, 4 and 8. Each write restarts tuning: the gains are reloaded
// from all three registers, deltas become a tenth of each gain and the
// tolerance a fifth of the delta sum. The restart then steps through its load,
// delta and tolerance states, with in_ch.ready low. Reads return the registers.
// Each transaction on in_ch carries one error sample; each produces exactly
// one transaction on out_ch with the three gains after the step and the
// converged flag. A sample is held in an input register and the step is
// done from there into the output register, which holds the result until
// out_ch takes it; one sample per cycle is taken as long as out_ch keeps up
// and no restart is running. The step is a single pass of the delta sum
// compare and one constant multiply for delta growth or shrinkage.
// When out_ch stalls, the result holds and one more sample can wait in the
// input register; in_ch.ready drops after that. Reset (rst, synchronous)
// clears registers, gains, deltas, tolerance, phase, index and best error.
`default_nettype none

module twiddle_gain_tuner import tgt_pkg::*; #(
  parameter int GAIN_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  tgt_in_if.sink            in_ch,
  tgt_out_if.source         out_ch
);

  localparam int W = GAIN_WIDTH;
  localparam int MW = W + K_W;
  localparam int PW = SUM_W + K_W;
  // The sum of three W-bit deltas fits in W+2 bits.
  localparam int SW = W + 2;
  localparam int QW = SW + K_W;
  localparam logic signed [PW-1:0] MAXW = (PW'(1) <<< (W - 1)) - PW'(1);
  localparam logic signed [PW-1:0] MINW = -MAXW - PW'(1);
  localparam logic signed [MW-1:0] RND_W = MW'(1) <<< (FRAC - 1);
  localparam logic signed [QW-1:0] RND_S = QW'(1) <<< (FRAC - 1);

  function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] x);
    logic signed [W-1:0] r;
    if (x > MAXW) begin
      r = MAXW[W-1:0];
    end else if (x < MINW) begin
      r = MINW[W-1:0];
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat64(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] r;
    if (x > MAX64) begin
      r = MAX64;
    end else if (x < MIN64) begin
      r = MIN64;
    end else begin
      r = x;
    end
    return r;
  endfunction

  // Round to nearest, ties up: floor((v*k + 2^29) / 2^30).
  function automatic logic signed [W-1:0] scale_w(input logic signed [W-1:0] v,
                                                  input logic signed [K_W-1:0] k);
    logic signed [MW-1:0] p;
    logic signed [MW-1:0] q;
    p = v * k + RND_W;
    q = p >>> FRAC;
    return sat_w(PW'(q));
  endfunction

  function automatic logic signed [W-1:0] scale_s(input logic signed [SW-1:0] v,
                                                  input logic signed [K_W-1:0] k);
    logic signed [QW-1:0] p;
    logic signed [QW-1:0] q;
    p = v * k + RND_S;
    q = p >>> FRAC;
    return sat_w(PW'(q));
  endfunction

  // Configuration registers and restart sequencer.
  logic signed [DATA_W-1:0] reg_val [NUM_GAINS];
  logic                     wr_en;
  logic [1:0]               wr_idx;
  logic                     wr_hit;
  restart_t                 rs_state;
  restart_t                 rs_state_next;
  restart_ctl_t             rs_ctl;

  // Tuning state.
  logic signed [W-1:0]      gains [NUM_GAINS];
  logic signed [W-1:0]      deltas [NUM_GAINS];
  logic signed [W-1:0]      gains_next [NUM_GAINS];
  logic signed [W-1:0]      deltas_next [NUM_GAINS];
  logic signed [W-1:0]      tolerance;
  logic signed [DATA_W-1:0] record_err;
  logic signed [DATA_W-1:0] record_err_next;
  phase_t                   phase;
  phase_t                   phase_next;
  logic [1:0]               coord_index;
  logic [1:0]               coord_index_next;

  // Input and output registers.
  logic                     in_full;
  logic signed [DATA_W-1:0] sample;
  logic                     out_valid;
  logic                     fire;

  // Step datapath.
  logic signed [SUM_W-1:0]  delta_sum;
  logic signed [SUM_W-1:0]  pair_sum;
  logic                     conv;
  logic                     improve;
  logic signed [W-1:0]      g_sel;
  logic signed [W-1:0]      d_sel;
  logic signed [K_W-1:0]    k_sel;
  logic signed [W-1:0]      d_scaled;
  logic signed [W-1:0]      g_plus;
  logic signed [W-1:0]      g_minus;
  logic signed [SUM_W-1:0]  d_twice;
  logic [1:0]               coord_after;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = paddr[3:2];
  assign wr_hit = wr_en && (wr_idx == REG_KP || wr_idx == REG_KD || wr_idx == REG_KI);

  always_comb begin
    unique case (paddr[3:2])
      REG_KP:  prdata = reg_val[0];
      REG_KD:  prdata = reg_val[1];
      REG_KI:  prdata = reg_val[2];
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_GAINS; j++) begin
        reg_val[j] <= '0;
      end
    end else if (wr_hit) begin
      for (int j = 0; j < NUM_GAINS; j++) begin
        if (wr_idx == 2'(j)) begin
          reg_val[j] <= pwdata;
        end
      end
    end
  end

  // A write during a restart simply starts it over with the new values.
  always_comb begin
    if (wr_hit) begin
      rs_state_next = RS_LOAD;
    end else begin
      unique case (rs_state)
        RS_LOAD:  rs_state_next = RS_DELTA;
        RS_DELTA: rs_state_next = RS_TOL;
        RS_TOL:   rs_state_next = RS_IDLE;
        default:  rs_state_next = RS_IDLE;
      endcase
    end
  end

  always_comb begin
    rs_ctl = '0;
    unique case (rs_state)
      RS_LOAD:  rs_ctl.load_gains = 1'b1;
      RS_DELTA: rs_ctl.load_deltas = 1'b1;
      RS_TOL:   rs_ctl.load_tol = 1'b1;
      default:  rs_ctl.busy = 1'b0;
    endcase
    rs_ctl.busy = (rs_state != RS_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rs_state <= RS_IDLE;
    end else begin
      rs_state <= rs_state_next;
    end
  end

  // Handshakes.
  assign fire        = in_full && (!out_valid || out_ch.ready);
  assign in_ch.ready = !rs_ctl.busy && (!in_full || fire);
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ch.ready) begin
      in_full <= in_ch.valid;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample <= in_ch.error_sample;
    end
  end

  // Delta sum saturates after each add, as two chained 64-bit adds would.
  always_comb begin
    pair_sum  = sat64(SUM_W'(deltas[0]) + SUM_W'(deltas[1]));
    delta_sum = sat64(pair_sum + SUM_W'(deltas[2]));
  end

  assign conv    = delta_sum < SUM_W'(tolerance);
  assign improve = sample < record_err;

  always_comb begin
    unique case (coord_index)
      2'd1: begin
        g_sel = gains[1];
        d_sel = deltas[1];
      end
      2'd2: begin
        g_sel = gains[2];
        d_sel = deltas[2];
      end
      default: begin
        g_sel = gains[0];
        d_sel = deltas[0];
      end
    endcase
  end

  assign coord_after = (coord_index == LAST_IDX) ? 2'd0 : coord_index + 2'd1;
  assign k_sel    = (phase == PH_DOWN && !improve) ? K_SHRINK : K_GROW;
  assign d_scaled = scale_w(d_sel, k_sel);
  assign g_plus   = sat_w(PW'(SUM_W'(g_sel) + SUM_W'(d_sel)));
  assign d_twice  = sat64(SUM_W'(d_sel) + SUM_W'(d_sel));
  assign g_minus  = sat_w(PW'(sat64(SUM_W'(g_sel) - d_twice)));

  always_comb begin
    gains_next       = gains;
    deltas_next      = deltas;
    record_err_next  = record_err;
    phase_next       = phase;
    coord_index_next = coord_index;
    if (!conv) begin
      unique case (phase)
        PH_UP: begin
          if (improve) begin
            record_err_next  = sample;
            coord_index_next = coord_after;
            phase_next       = PH_START;
          end else begin
            phase_next = PH_DOWN;
          end
          for (int j = 0; j < NUM_GAINS; j++) begin
            if (coord_index == 2'(j)) begin
              if (improve) begin
                deltas_next[j] = d_scaled;
              end else begin
                gains_next[j] = g_minus;
              end
            end
          end
        end
        PH_DOWN: begin
          if (improve) begin
            record_err_next = sample;
          end
          for (int j = 0; j < NUM_GAINS; j++) begin
            if (coord_index == 2'(j)) begin
              deltas_next[j] = d_scaled;
              if (!improve) begin
                gains_next[j] = g_plus;
              end
            end
          end
          coord_index_next = coord_after;
          phase_next       = PH_START;
        end
        default: begin
          record_err_next = sample;
          for (int j = 0; j < NUM_GAINS; j++) begin
            if (coord_index == 2'(j)) begin
              gains_next[j] = g_plus;
            end
          end
          phase_next = PH_UP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NUM_GAINS; j++) begin
        gains[j]  <= '0;
        deltas[j] <= '0;
      end
      tolerance   <= '0;
      record_err  <= '0;
      phase       <= PH_START;
      coord_index <= '0;
    end else if (rs_ctl.load_gains) begin
      for (int j = 0; j < NUM_GAINS; j++) begin
        gains[j] <= sat_w(PW'(reg_val[j]));
      end
      phase       <= PH_START;
      coord_index <= '0;
    end else if (rs_ctl.load_deltas) begin
      for (int j = 0; j < NUM_GAINS; j++) begin
        deltas[j] <= scale_w(gains[j], K_TENTH);
      end
    end else if (rs_ctl.load_tol) begin
      tolerance <= scale_s(SW'(delta_sum), K_FIFTH);
    end else if (fire) begin
      gains       <= gains_next;
      deltas      <= deltas_next;
      record_err  <= record_err_next;
      phase       <= phase_next;
      coord_index <= coord_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.gain_p    <= DATA_W'(gains_next[0]);
      out_ch.gain_d    <= DATA_W'(gains_next[1]);
      out_ch.gain_i    <= DATA_W'(gains_next[2]);
      out_ch.converged <= conv;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for twiddle_gain_tuner: directed script, then random tuning runs.
module tb;
  import tgt_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_AT = 700;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 100;
  localparam logic [1:0] REG_NONE = 2'd3;

  // Scale factors in Q2.30, kept apart from the design's own copies.
  localparam longint TENTH_Q30 = 64'sd107374182;
  localparam longint FIFTH_Q30 = 64'sd214748365;
  localparam longint GROW_Q30 = 64'sd1181116006;
  localparam longint SHRINK_Q30 = 64'sd966367642;
  localparam longint GAIN_MAX = 64'sd2147483647;
  localparam longint GAIN_MIN = -64'sd2147483648;

  typedef enum int {ERR_UNIFORM, ERR_STALL, ERR_DESCEND, ERR_MIXED} err_mode_t;
  typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_HALF, RDY_SPARSE} rdy_mode_t;

  typedef struct packed {
    logic [31:0] p;
    logic [31:0] d;
    logic [31:0] i;
    logic        conv;
  } gains_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        typed;
    gains_t      want;
  } script_row_t;

  localparam gains_t ZERO_RES = '{32'h0, 32'h0, 32'h0, 1'b0};
  localparam gains_t MIN_RES = '{32'h80000000, 32'h00100000, 32'h00000001, 1'b1};
  localparam gains_t NEG_RES = '{32'hFFF00000, 32'h0, 32'h0, 1'b1};
  localparam int SCRIPT_LEN = 33;

  // Zero-state steps, saturation at the top, convergence on negative gains,
  // an ignored register index, then a plain positive run.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, REG_KP, 32'h00000000, 1'b1, ZERO_RES},
    '{1'b0, REG_KP, 32'h7FFFFFFF, 1'b1, ZERO_RES},
    '{1'b0, REG_KP, 32'h80000000, 1'b1, ZERO_RES},
    '{1'b0, REG_KP, 32'h00000000, 1'b1, ZERO_RES},
    '{1'b1, REG_KP, 32'h7FFFFFFF, 1'b0, ZERO_RES},
    '{1'b1, REG_KD, 32'h00100000, 1'b0, ZERO_RES},
    '{1'b1, REG_KI, 32'h00000001, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00100000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00200000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00300000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00000000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'hFFF00000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00000000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00000000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h80000000, 1'b0, ZERO_RES},
    '{1'b1, REG_KP, 32'h80000000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h12345678, 1'b1, MIN_RES},
    '{1'b0, REG_KP, 32'h7FFFFFFF, 1'b1, MIN_RES},
    '{1'b1, REG_NONE, 32'h00000000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00000000, 1'b1, MIN_RES},
    '{1'b1, REG_KP, 32'hFFF00000, 1'b0, ZERO_RES},
    '{1'b1, REG_KD, 32'h00000000, 1'b0, ZERO_RES},
    '{1'b1, REG_KI, 32'h00000000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h55555555, 1'b1, NEG_RES},
    '{1'b1, REG_KP, 32'h00100000, 1'b0, ZERO_RES},
    '{1'b1, REG_KD, 32'h00200000, 1'b0, ZERO_RES},
    '{1'b1, REG_KI, 32'h00300000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00500000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00400000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00400000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00600000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00300000, 1'b0, ZERO_RES},
    '{1'b0, REG_KP, 32'h00300000, 1'b0, ZERO_RES}
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tgt_in_if  in_if ();
  tgt_out_if out_if ();

  twiddle_gain_tuner dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_if),
    .out_ch  (out_if)
  );

  // Tuner state as the testbench sees it.
  longint    cfg_gain [3];
  longint    gain_q [3];
  longint    delta_q [3];
  phase_t    tune_phase;
  int        coord;
  longint    best_err;
  longint    tol_q;

  gains_t    pending_gains [$];
  int        samples_taken;
  int        burst_left;
  int        mismatches;
  int        cycle_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint sat_gain(input longint v);
    if (v > GAIN_MAX) return GAIN_MAX;
    if (v < GAIN_MIN) return GAIN_MIN;
    return v;
  endfunction

  // Multiply by a Q2.30 factor, rounding to nearest with ties upward.
  function automatic longint q30_scale(input longint v, input longint k);
    return (v * k + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void retune_from_regs();
    for (int n = 0; n < NUM_GAINS; n++) begin
      gain_q[n] = sat_gain(cfg_gain[n]);
      delta_q[n] = sat_gain(q30_scale(gain_q[n], TENTH_Q30));
    end
    coord = 0;
    tune_phase = PH_START;
    tol_q = sat_gain(q30_scale(delta_q[0] + delta_q[1] + delta_q[2], FIFTH_Q30));
  endfunction

  function automatic gains_t tune_step(input longint err);
    gains_t res;
    longint dsum;
    int     n;
    n = coord;
    dsum = delta_q[0] + delta_q[1] + delta_q[2];
    res.conv = 1'b0;
    if (dsum < tol_q) begin
      res.conv = 1'b1;
    end else begin
      case (tune_phase)
        PH_UP: begin
          if (err < best_err) begin
            best_err = err;
            delta_q[n] = sat_gain(q30_scale(delta_q[n], GROW_Q30));
            coord = (n + 1) % NUM_GAINS;
            tune_phase = PH_START;
          end else begin
            gain_q[n] = sat_gain(gain_q[n] - 2 * delta_q[n]);
            tune_phase = PH_DOWN;
          end
        end
        PH_DOWN: begin
          if (err < best_err) begin
            best_err = err;
            delta_q[n] = sat_gain(q30_scale(delta_q[n], GROW_Q30));
          end else begin
            gain_q[n] = sat_gain(gain_q[n] + delta_q[n]);
            delta_q[n] = sat_gain(q30_scale(delta_q[n], SHRINK_Q30));
          end
          coord = (n + 1) % NUM_GAINS;
          tune_phase = PH_START;
        end
        default: begin
          best_err = err;
          gain_q[n] = sat_gain(gain_q[n] + delta_q[n]);
          tune_phase = PH_UP;
        end
      endcase
    end
    res.p = gain_q[0][31:0];
    res.d = gain_q[1][31:0];
    res.i = gain_q[2][31:0];
    return res;
  endfunction

  // Leaves psel high so that another write can follow in the next cycle.
  task automatic write_gain_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx != REG_NONE) begin
      cfg_gain[idx] = longint'($signed(val));
      retune_from_regs();
    end
  endtask

  task automatic release_bus();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic offer_sample(input logic [31:0] e, input bit typed, input gains_t typed_res);
    gains_t predicted;
    int     gap_len;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
      gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap_len > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.error_sample <= e;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = tune_step(longint'($signed(e)));
    pending_gains.push_back(typed ? typed_res : predicted);
    samples_taken++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    gains_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_gains.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result without a pending sample, expected none, got %h %h %h %b",
                   $time, out_if.gain_p, out_if.gain_d, out_if.gain_i, out_if.converged);
      end else begin
        want = pending_gains.pop_front();
        check_field("gain_p", want.p, out_if.gain_p);
        check_field("gain_d", want.d, out_if.gain_d);
        check_field("gain_i", want.i, out_if.gain_i);
        check_field("converged", {31'b0, want.conv}, {31'b0, out_if.converged});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("twiddle_gain_tuner: mismatch");
      $finish;
    end
  end

  // Output side: ready follows a pattern of its own, with long holds that
  // back the block up into its input.
  initial begin
    int        span;
    int        holds_done;
    rdy_mode_t rmode;
    out_if.ready = 1'b0;
    holds_done = 0;
    forever begin
      rmode = rdy_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk);
        if (holds_done < 2 && samples_taken >= HOLD_AT * (holds_done + 1)) begin
          out_if.ready <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
          holds_done++;
        end
        case (rmode)
          RDY_ALWAYS: out_if.ready <= 1'b1;
          RDY_MOSTLY: out_if.ready <= ($urandom_range(0, 3) != 0);
          RDY_HALF:   out_if.ready <= 1'($urandom_range(0, 1));
          default:    out_if.ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin
    int          r;
    int          len;
    int          n_wr;
    int          random_taken;
    bit          bus_open;
    logic [1:0]  idx;
    logic [31:0] val;
    logic [31:0] e;
    longint      tmp;
    err_mode_t   mode;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.error_sample = '0;
    cycle_count = 0;
    samples_taken = 0;
    burst_left = 0;
    mismatches = 0;
    random_taken = 0;
    bus_open = 1'b0;
    for (int n = 0; n < NUM_GAINS; n++) begin
      cfg_gain[n] = 0;
      gain_q[n] = 0;
      delta_q[n] = 0;
    end
    tune_phase = PH_START;
    coord = 0;
    best_err = 0;
    tol_q = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < SCRIPT_LEN; r++) begin
      if (SCRIPT[r].is_cfg) begin
        if (!bus_open) drain_results();
        write_gain_reg(SCRIPT[r].reg_idx, SCRIPT[r].value);
        bus_open = 1'b1;
      end else begin
        if (bus_open) begin
          release_bus();
          bus_open = 1'b0;
        end
        offer_sample(SCRIPT[r].value, SCRIPT[r].typed, SCRIPT[r].want);
      end
    end

    // Each run writes fresh gains (a restart unless all writes hit REG_NONE), then
    // feeds a stream of errors shaped to drive convergence, delta growth, or both.
    while (random_taken < RANDOM_ITEMS) begin
      drain_results();
      n_wr = $urandom_range(1, 3);
      repeat (n_wr) begin
        idx = ($urandom_range(0, 9) == 0) ? REG_NONE : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 9))
          0: val = 32'h00000000;
          1: val = 32'h7FFFFFFF;
          2: val = 32'h80000000;
          3: val = $urandom();
          4: val = -$urandom_range(1, 32'h04000000);
          default: val = $urandom_range(1, 32'h04000000);
        endcase
        write_gain_reg(idx, val);
      end
      release_bus();
      mode = err_mode_t'($urandom_range(0, 3));
      len = (mode == ERR_STALL) ? $urandom_range(150, 300) : $urandom_range(40, 200);
      if (len > RANDOM_ITEMS - random_taken) len = RANDOM_ITEMS - random_taken;
      repeat (len) begin
        if (mode == ERR_MIXED) begin
          r = $urandom_range(0, 9);
          if (r == 0) mode = ERR_UNIFORM;
          else if (r < 5) mode = ERR_STALL;
          else mode = ERR_DESCEND;
        end
        case (mode)
          ERR_STALL: begin
            tmp = sat_gain(best_err + longint'($urandom_range(0, 32'hFFFF)));
            e = tmp[31:0];
          end
          ERR_DESCEND: begin
            tmp = sat_gain(best_err - longint'($urandom_range(1, 32'hFFFF)));
            e = tmp[31:0];
          end
          default: begin
            if ($urandom_range(0, 15) == 0)
              e = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            else
              e = $urandom();
          end
        endcase
        offer_sample(e, 1'b0, ZERO_RES);
        random_taken++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("twiddle_gain_tuner: match");
    end else begin
      $display("twiddle_gain_tuner: mismatch");
    end
    $finish;
  end

endmodule
